FILE: rtl/lzw_byte_encoder_unit_defines.svh
// Assertion macros for the LZW byte encoder.
`ifndef LZW_BYTE_ENCODER_UNIT_DEFINES_SVH
`define LZW_BYTE_ENCODER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define LBE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define LBE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LBE_ASSERT(lbl, prop, msg)
`define LBE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/lbe_pkg.sv
// ----------------------------------------------------------------------------
// lbe_pkg
// Types, constants and helpers shared by the LZW byte encoder modules.
// ----------------------------------------------------------------------------
package lbe_pkg;
	localparam int CODE_WIDTH_DEF = 12;
	localparam int HASH_DEPTH_DEF = 8192;
	localparam int FIRST_FREE     = 256;
	localparam int CODE_OUT_W     = 12;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} lbe_in_t;

	typedef struct packed {
		logic [CODE_OUT_W-1:0] code_value;
		logic                  last_code;
		logic [3:0]            code_bits;
	} lbe_out_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_FINAL
	} lbe_state_t;

	// Position of the highest set bit plus one.
	function automatic logic [4:0] code_width(input logic [16:0] v);
		logic [4:0] w;
		w = '0;
		for (int i = 0; i < 17; i++) begin
			if (v[i]) begin
				w = 5'(i + 1);
			end
		end
		return w;
	endfunction
endpackage

FILE: rtl/lzw_byte_encoder_unit.sv
// An accepted byte is registered in ST_IDLE, its home slot is read in ST_READ
// and decided in ST_CHECK; each further probe repeats ST_READ and ST_CHECK, and
// a final code follows in ST_FINAL. A new byte is taken only back in ST_IDLE,
// after the table read and check of the last one; the first byte of a message
// only becomes the prefix. Reset and every accepted final code start a clearing
// pass over the whole table, during which no byte is taken.
`include "lzw_byte_encoder_unit_defines.svh"
// ----------------------------------------------------------------------------
// lzw_byte_encoder_unit
// Streaming LZW encoder: byte queue, dictionary engine and code queue.
// ----------------------------------------------------------------------------
module lzw_byte_encoder_unit import lbe_pkg::*; #(
	parameter int CODE_WIDTH = CODE_WIDTH_DEF,
	parameter int HASH_DEPTH = HASH_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  lbe_in_t  item,
	output logic     code_valid,
	input  logic     code_stall,
	output lbe_out_t code
);
	logic     eng_in_valid;
	logic     eng_in_stall;
	lbe_in_t  eng_in_word;
	logic     eng_out_valid;
	logic     eng_out_stall;
	lbe_out_t eng_out_word;

	lbe_fifo #(.W($bits(lbe_in_t))) u_in_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (item_valid),
		.push_stall (item_stall),
		.push_data  (item),
		.pop_valid  (eng_in_valid),
		.pop_stall  (eng_in_stall),
		.pop_data   (eng_in_word)
	);

	lbe_engine #(.CODE_WIDTH(CODE_WIDTH), .HASH_DEPTH(HASH_DEPTH)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (eng_in_valid),
		.in_stall  (eng_in_stall),
		.in_word   (eng_in_word),
		.out_valid (eng_out_valid),
		.out_stall (eng_out_stall),
		.out_word  (eng_out_word)
	);

	lbe_fifo #(.W($bits(lbe_out_t))) u_out_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (eng_out_valid),
		.push_stall (eng_out_stall),
		.push_data  (eng_out_word),
		.pop_valid  (code_valid),
		.pop_stall  (code_stall),
		.pop_data   (code)
	);

	`LBE_ASSERT(a_bits_on_last, !(eng_out_valid && eng_out_word.last_code) || (CODE_WIDTH > 14) || (eng_out_word.code_bits >= 4'd9), "final code width below nine bits")
	`LBE_ASSERT(a_bits_zero, !(eng_out_valid && !eng_out_word.last_code) || (eng_out_word.code_bits == 4'd0), "code width set on a non-final code")
	`LBE_ASSERT_NEXT(a_final_clears, eng_out_valid && eng_out_word.last_code && !eng_out_stall, eng_in_stall, "byte taken right after a final code")
endmodule

FILE: rtl/lbe_fifo.sv
// ----------------------------------------------------------------------------
// lbe_fifo
// Two-entry queue that decouples a producer from a consumer.
// ----------------------------------------------------------------------------
module lbe_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_stall,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_stall,
	output logic [W-1:0] pop_data
);
	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;
	logic         push;
	logic         pop;

	assign push_stall = (cnt_q == 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

FILE: rtl/lbe_engine.sv
// ----------------------------------------------------------------------------
// lbe_engine
// Dictionary engine: hash probing, pair insertion and code emission.
// ----------------------------------------------------------------------------
module lbe_engine import lbe_pkg::*; #(
	parameter int CODE_WIDTH = CODE_WIDTH_DEF,
	parameter int HASH_DEPTH = HASH_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  lbe_in_t  in_word,
	output logic     out_valid,
	input  logic     out_stall,
	output lbe_out_t out_word
);
	localparam int CW    = CODE_WIDTH;
	localparam int HW    = $clog2(HASH_DEPTH);
	localparam int ENT_W = 1 + CW + 8 + CW;

	lbe_state_t       state_q, state_d;
	logic [CW-1:0]    prefix_q;
	logic             pvalid_q;
	logic [CW:0]      nfc_q;
	logic [HW-1:0]    clr_q;
	logic [HW-1:0]    slot_q;
	logic [HW:0]      nprobe_q;
	logic [7:0]       byte_q;
	logic             last_q;

	logic [ENT_W-1:0] tbl_q [HASH_DEPTH];
	logic [ENT_W-1:0] rdata_q;
	logic             mem_we;
	logic [HW-1:0]    mem_waddr;
	logic [ENT_W-1:0] mem_wdata;

	logic             e_valid;
	logic [CW-1:0]    e_pfx;
	logic [7:0]       e_byte;
	logic [CW-1:0]    e_code;
	logic             hit;
	logic             miss;
	logic             insert_ok;
	logic             take;
	logic [31:0]      hash;
	logic [4:0]       fin_bits;

	assign e_valid   = rdata_q[ENT_W-1];
	assign e_pfx     = rdata_q[ENT_W-2 -: CW];
	assign e_byte    = rdata_q[CW+7 -: 8];
	assign e_code    = rdata_q[CW-1:0];
	assign hit       = e_valid && (e_pfx == prefix_q) && (e_byte == byte_q);
	// A miss is an empty slot, or a full sweep of the table without a match.
	assign miss      = !hit && (!e_valid || (nprobe_q == (HW+1)'(HASH_DEPTH - 1)));
	assign insert_ok = !nfc_q[CW] && !e_valid;
	assign take      = (state_q == ST_IDLE) && in_valid;
	assign hash      = (32'(prefix_q) << 8) + 32'(prefix_q) + 32'(in_word.data_byte);
	assign fin_bits  = code_width(17'(nfc_q));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == HW'(HASH_DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (pvalid_q) state_d = ST_READ;
					else if (in_word.last_byte) state_d = ST_FINAL;
				end
			end
			ST_READ: state_d = ST_CHECK;
			ST_CHECK: begin
				if (hit || (miss && !out_stall)) begin
					state_d = last_q ? ST_FINAL : ST_IDLE;
				end else if (!miss) begin
					state_d = ST_READ;
				end
			end
			ST_FINAL: begin
				if (!out_stall) state_d = ST_CLEAR;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_stall            = (state_q != ST_IDLE);
		out_valid           = 1'b0;
		out_word.code_value = CODE_OUT_W'(prefix_q);
		out_word.last_code  = 1'b0;
		out_word.code_bits  = 4'd0;
		mem_we              = 1'b0;
		mem_waddr           = slot_q;
		mem_wdata           = {1'b1, prefix_q, byte_q, nfc_q[CW-1:0]};
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_CHECK: begin
				out_valid = miss;
				mem_we    = miss && !out_stall && insert_ok;
			end
			ST_FINAL: begin
				out_valid          = 1'b1;
				out_word.last_code = 1'b1;
				out_word.code_bits = fin_bits[3:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_q[mem_waddr] <= mem_wdata;
		end
		if (state_q == ST_READ) begin
			rdata_q <= tbl_q[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			prefix_q <= '0;
			pvalid_q <= 1'b0;
			nfc_q    <= (CW+1)'(FIRST_FREE);
			clr_q    <= '0;
			slot_q   <= '0;
			nprobe_q <= '0;
			byte_q   <= '0;
			last_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + HW'(1);
				ST_IDLE: begin
					if (take) begin
						byte_q <= in_word.data_byte;
						last_q <= in_word.last_byte;
						if (!pvalid_q) begin
							prefix_q <= CW'(in_word.data_byte);
							pvalid_q <= 1'b1;
						end else begin
							slot_q   <= hash[HW-1:0];
							nprobe_q <= '0;
						end
					end
				end
				ST_CHECK: begin
					if (hit) begin
						prefix_q <= e_code;
					end else if (miss) begin
						if (!out_stall) begin
							prefix_q <= CW'(byte_q);
							if (insert_ok) nfc_q <= nfc_q + (CW+1)'(1);
						end
					end else begin
						slot_q   <= slot_q + HW'(1);
						nprobe_q <= nprobe_q + (HW+1)'(1);
					end
				end
				ST_FINAL: begin
					if (!out_stall) begin
						prefix_q <= '0;
						pvalid_q <= 1'b0;
						nfc_q    <= (CW+1)'(FIRST_FREE);
						clr_q    <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end
endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the LZW byte encoder: bytes go in through a bursty sender, and
// every emitted code is compared with a software dictionary kept in step.
// ----------------------------------------------------------------------------
module tb_top;
	import lbe_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DICT_LIMIT = 1 << CODE_WIDTH_DEF;
	localparam int IDLE_LIMIT = 60000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     item_valid = 1'b0;
	logic     item_stall;
	lbe_in_t  item = '0;
	logic     code_valid;
	logic     code_stall = 1'b0;
	lbe_out_t code;

	lzw_byte_encoder_unit dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.code_valid(code_valid), .code_stall(code_stall), .code(code)
	);

	always #5 clk = ~clk;

	// Software copy of the encoder state.
	int        prefix;
	bit        have_prefix;
	int        next_code;
	int        dict[int];
	lbe_out_t  code_q[$];
	int        errors = 0;
	int        burst_left = 0;
	int        hold_cycles = 0;

	function automatic logic [3:0] bits_of(int v);
		int w = 0;
		while (v != 0) begin
			w++;
			v = v >> 1;
		end
		return 4'(w);
	endfunction

	function automatic lbe_out_t make_code(int c, bit fin, logic [3:0] b);
		lbe_out_t o;
		o.code_value = CODE_OUT_W'(c);
		o.last_code = fin;
		o.code_bits = b;
		return o;
	endfunction

	function automatic void expect_code(lbe_out_t o);
		code_q = {code_q, o};
	endfunction

	function automatic void clear_dict();
		prefix = 0;
		have_prefix = 0;
		next_code = FIRST_FREE;
		dict.delete();
	endfunction

	function automatic void encode_byte(logic [7:0] b, bit fin);
		int key;
		if (!have_prefix) begin
			prefix = b;
			have_prefix = 1;
		end else begin
			key = (prefix << 8) | b;
			if (dict.exists(key)) begin
				prefix = dict[key];
			end else begin
				expect_code(make_code(prefix, 1'b0, 4'd0));
				if (next_code < DICT_LIMIT) begin
					dict[key] = next_code;
					next_code++;
				end
				prefix = b;
			end
		end
		if (fin) begin
			expect_code(make_code(prefix, 1'b1, bits_of(next_code)));
			clear_dict();
		end
	endfunction

	// Offer one byte; the word is predicted at the edge where it is taken.
	task automatic send_byte(logic [7:0] b, bit fin);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		item_valid <= 1'b1;
		item <= '{data_byte: b, last_byte: fin};
		do @(posedge clk); while (item_stall);
		encode_byte(b, fin);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic idle_sender();
		item_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		idle_sender();
		wait (code_q.size() == 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic send_message(int len, int alphabet);
		for (int i = 0; i < len; i++) begin
			send_byte(8'($urandom_range(alphabet - 1)), i == len - 1);
		end
	endtask

	task automatic test_directed();
		send_byte(8'hff, 1'b1);
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b1);
		for (int i = 0; i < 12; i++) send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h61, 1'b1);
		wait_drained();
	endtask

	// One long message over the full byte range, so the table sees many pairs.
	task automatic test_long_message();
		send_message(300, 256);
		wait_drained();
	endtask

	task automatic test_backpressure();
		hold_cycles = 700;
		send_message(150, 8);
		wait_drained();
	endtask

	task automatic test_random();
		int total = 0;
		int len;
		while (total < 600) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 80);
			send_message(len, ($urandom_range(1) == 0) ? 256 : $urandom_range(2, 16));
			total += len;
		end
		wait_drained();
	endtask

	// Receiver stall pattern: an optional forced hold, then phases of none, light and heavy stalling.
	int stall_pct = 0;
	int phase_left = 0;
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			code_stall <= 1'b1;
		end else begin
			if (phase_left == 0) begin
				case ($urandom_range(2))
					0: stall_pct = 0;
					1: stall_pct = 25;
					default: stall_pct = 70;
				endcase
				phase_left = $urandom_range(10, 120);
			end
			phase_left--;
			code_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	lbe_out_t exp_code;
	always @(posedge clk) begin
		if (arst_n && code_valid && !code_stall) begin
			if (code_q.size() == 0) begin
				$error("unexpected code word %h", code);
				errors++;
			end else begin
				exp_code = code_q.pop_front();
				if (code.code_value !== exp_code.code_value) begin
					$error("code_value expected %0d actual %0d",
						exp_code.code_value, code.code_value);
					errors++;
				end
				if (code.last_code !== exp_code.last_code) begin
					$error("last_code expected %0d actual %0d",
						exp_code.last_code, code.last_code);
					errors++;
				end
				if (code.code_bits !== exp_code.code_bits) begin
					$error("code_bits expected %0d actual %0d",
						exp_code.code_bits, code.code_bits);
					errors++;
				end
			end
		end
	end

	int idle_count = 0;
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (code_valid && !code_stall)) begin
			idle_count <= 0;
		end else if (idle_count >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_count <= idle_count + 1;
		end
	end

	initial begin
		clear_dict();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_backpressure();
		test_long_message();
		test_random();
		repeat (50) @(negedge clk);
		if (errors == 0 && code_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/lbe_pkg.sv
rtl/lbe_fifo.sv
rtl/lbe_engine.sv
rtl/lzw_byte_encoder_unit.sv
tb/sv/tb_top.sv
